>>> rtl/core/tlfs_pkg.sv
// Shared types and constants of the two-level feedback scheduler.
`default_nettype none

package tlfs_pkg;

    // Field widths that do not vary
    localparam int OP_W      = 3;
    localparam int USED_W    = 17;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int QSEL_W    = 2;
    localparam int NUM_Q     = 3;

    // Event codes
    localparam logic [OP_W-1:0] OP_ADD        = 3'd0;
    localparam logic [OP_W-1:0] OP_FINISH     = 3'd1;
    localparam logic [OP_W-1:0] OP_BLOCK      = 3'd2;
    localparam logic [OP_W-1:0] OP_NOTIFY     = 3'd3;
    localparam logic [OP_W-1:0] OP_NOTIFY_ALL = 3'd4;
    localparam logic [OP_W-1:0] OP_TICK       = 3'd5;

    // Queue selects
    localparam logic [QSEL_W-1:0] Q_FIRST   = 2'd0;
    localparam logic [QSEL_W-1:0] Q_SECOND  = 2'd1;
    localparam logic [QSEL_W-1:0] Q_BLOCKED = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_QUANTUM  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_QUANTUM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_INTERVAL  = 2'd2;

    // Queue operations of one cycle: one push and one pop, any queues
    typedef struct packed {
        logic              push;
        logic [QSEL_W-1:0] push_q;
        logic              pop;
        logic [QSEL_W-1:0] pop_q;
    } t_qop;

    // Queue occupancy flags, one bit per queue
    typedef struct packed {
        logic [NUM_Q-1:0] empty;
        logic [NUM_Q-1:0] full;
    } t_qstat;

    // Configuration registers
    typedef struct packed {
        logic [CFG_W-1:0] first_quantum;
        logic [CFG_W-1:0] second_quantum;
        logic [CFG_W-1:0] tick_interval;
    } t_cfg;

endpackage

`default_nettype wire

>>> rtl/core/tlfs_qmem.sv
// Shared queue storage: one synchronous RAM holding all three queues.
`default_nettype none

module tlfs_qmem import tlfs_pkg::*; #(
    parameter  int QUEUE_DEPTH = 16,
    parameter  int DATA_W      = 25,
    localparam int PW          = $clog2(QUEUE_DEPTH),
    localparam int AW          = $clog2(NUM_Q * QUEUE_DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [QSEL_W-1:0] i_wq,
    input  wire logic [PW-1:0]     i_wslot,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [QSEL_W-1:0] i_rq,
    input  wire logic [PW-1:0]     i_rslot,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [NUM_Q*QUEUE_DEPTH];
    logic [DATA_W-1:0] r_rdata;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;

    // Each queue owns a contiguous region of the RAM
    function automatic logic [AW-1:0] qaddr(input logic [QSEL_W-1:0] q,
                                           input logic [PW-1:0] slot);
        logic [AW-1:0] base;
        unique case (q)
            Q_SECOND:  base = AW'(QUEUE_DEPTH);
            Q_BLOCKED: base = AW'(2 * QUEUE_DEPTH);
            default:   base = '0;
        endcase
        return base + AW'(slot);
    endfunction

    assign waddr = qaddr(i_wq, i_wslot);
    assign raddr = qaddr(i_rq, i_rslot);

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[waddr] <= i_wdata;
        end
    end

    // Read port, registered data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/tlfs_qptr.sv
// Head and count registers of the three queues, with slot addresses.
`default_nettype none

module tlfs_qptr import tlfs_pkg::*; #(
    parameter  int QUEUE_DEPTH = 16,
    localparam int PW          = $clog2(QUEUE_DEPTH),
    localparam int CW          = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_qop          i_qop,
    output t_qstat             o_stat,
    output logic      [PW-1:0] o_tail_slot,
    output logic      [PW-1:0] o_head_slot
);

    logic [PW-1:0] r_head  [NUM_Q];
    logic [CW-1:0] r_count [NUM_Q];
    logic [PW-1:0] tail    [NUM_Q];

    genvar g;
    generate
        for (g = 0; g < NUM_Q; g++) begin : g_lane
            logic          push_hit;
            logic          pop_hit;
            logic [PW:0]   tail_sum;

            assign push_hit = i_qop.push && (i_qop.push_q == QSEL_W'(g));
            assign pop_hit  = i_qop.pop && (i_qop.pop_q == QSEL_W'(g));

            // Tail slot = head + count, wrapped at the depth
            assign tail_sum = (PW+1)'(r_head[g]) + (PW+1)'(r_count[g]);
            assign tail[g]  = (tail_sum >= (PW+1)'(QUEUE_DEPTH))
                            ? PW'(tail_sum - (PW+1)'(QUEUE_DEPTH))
                            : PW'(tail_sum);

            assign o_stat.empty[g] = (r_count[g] == '0);
            assign o_stat.full[g]  = (r_count[g] == CW'(QUEUE_DEPTH));

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_head[g]  <= '0;
                    r_count[g] <= '0;
                end else begin
                    if (pop_hit) begin
                        r_head[g] <= (r_head[g] == PW'(QUEUE_DEPTH - 1))
                                   ? '0 : r_head[g] + 1'b1;
                    end
                    if (push_hit && !pop_hit) begin
                        r_count[g] <= r_count[g] + 1'b1;
                    end else if (pop_hit && !push_hit) begin
                        r_count[g] <= r_count[g] - 1'b1;
                    end
                end
            end
        end
    endgenerate

    // Slot selection for the RAM ports
    always_comb begin
        unique case (i_qop.push_q)
            Q_SECOND:  o_tail_slot = tail[1];
            Q_BLOCKED: o_tail_slot = tail[2];
            default:   o_tail_slot = tail[0];
        endcase
        unique case (i_qop.pop_q)
            Q_SECOND:  o_head_slot = r_head[1];
            Q_BLOCKED: o_head_slot = r_head[2];
            default:   o_head_slot = r_head[0];
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/tlfs_ctrl.sv
// Event sequencer: running-thread state and queue read-modify-write control.
`default_nettype none

module tlfs_ctrl import tlfs_pkg::*; #(
    parameter  int ID_WIDTH = 8,
    localparam int DW       = ID_WIDTH + USED_W
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic [OP_W-1:0]     i_op,
    input  wire logic [ID_WIDTH-1:0] i_thread_id,
    input  wire t_cfg                i_cfg,
    input  wire t_qstat              i_stat,
    input  wire logic [DW-1:0]       i_rdata,
    input  wire logic                i_out_free,
    output t_qop                     o_qop,
    output logic      [DW-1:0]       o_wdata,
    output logic                     o_in_ready,
    output logic                     o_done,
    output logic      [ID_WIDTH-1:0] o_running_id,
    output logic                     o_is_idle,
    output logic                     o_dropped
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_WAKE = 3'd2;
    localparam logic [2:0] S_SRD  = 3'd3;
    localparam logic [2:0] S_SWB  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [OP_W-1:0]     r_op, n_op;
    logic [ID_WIDTH-1:0] r_tid, n_tid;
    logic [ID_WIDTH-1:0] r_run, n_run;
    logic [USED_W-1:0]   r_used, n_used;
    logic [CFG_W-1:0]    r_quant, n_quant;
    logic                r_idle, n_idle;
    logic                r_lvl2, n_lvl2;
    logic                r_src2, n_src2;
    logic                r_drop, n_drop;

    logic [USED_W:0]     tick_sum;
    logic [USED_W-1:0]   used_sat;

    // Saturating usage update for a tick
    assign tick_sum = {1'b0, r_used} + (USED_W+1)'(i_cfg.tick_interval);
    assign used_sat = tick_sum[USED_W] ? '1 : tick_sum[USED_W-1:0];

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_tid   = r_tid;
        n_run   = r_run;
        n_used  = r_used;
        n_quant = r_quant;
        n_idle  = r_idle;
        n_lvl2  = r_lvl2;
        n_src2  = r_src2;
        n_drop  = r_drop;
        o_qop   = '0;
        o_wdata = '0;
        o_in_ready = 1'b0;
        o_done     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_accept) begin
                    n_op    = i_op;
                    n_tid   = i_thread_id;
                    n_drop  = 1'b0;
                    n_state = S_EXEC;
                end
            end

            // Decode the event, push where needed, start a head read
            S_EXEC: begin
                n_state = S_DONE;
                unique case (r_op)
                    OP_ADD: begin
                        o_qop.push_q = Q_FIRST;
                        o_wdata      = {r_tid, USED_W'(0)};
                        if (!i_stat.full[Q_FIRST]) begin
                            o_qop.push = 1'b1;
                        end else begin
                            n_drop = 1'b1;
                        end
                    end
                    OP_FINISH: begin
                        n_state = S_SRD;
                    end
                    OP_BLOCK: begin
                        o_qop.push_q = Q_BLOCKED;
                        o_wdata      = {r_run, USED_W'(0)};
                        if (!r_idle) begin
                            if (!i_stat.full[Q_BLOCKED]) begin
                                o_qop.push = 1'b1;
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        n_state = S_SRD;
                    end
                    OP_NOTIFY, OP_NOTIFY_ALL: begin
                        o_qop.pop_q = Q_BLOCKED;
                        if (!i_stat.empty[Q_BLOCKED]) begin
                            o_qop.pop = 1'b1;
                            n_state   = S_WAKE;
                        end
                    end
                    OP_TICK: begin
                        o_qop.push_q = Q_SECOND;
                        if (r_idle) begin
                            n_state = S_SRD;
                        end else begin
                            n_used = used_sat;
                            priority if (used_sat >= USED_W'(r_quant)) begin
                                // quantum used up: demote with zero usage
                                o_wdata = {r_run, USED_W'(0)};
                                if (!i_stat.full[Q_SECOND]) begin
                                    o_qop.push = 1'b1;
                                end else begin
                                    n_drop = 1'b1;
                                end
                                n_state = S_SRD;
                            end else if (r_lvl2 && !i_stat.empty[Q_FIRST]) begin
                                // preempt back to the second queue
                                o_wdata = {r_run, used_sat};
                                if (!i_stat.full[Q_SECOND]) begin
                                    o_qop.push = 1'b1;
                                end else begin
                                    n_drop = 1'b1;
                                end
                                n_state = S_SRD;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            // Blocked head arrives; move it to the first queue
            S_WAKE: begin
                o_qop.push_q = Q_FIRST;
                o_qop.pop_q  = Q_BLOCKED;
                o_wdata      = {i_rdata[DW-1 -: ID_WIDTH], USED_W'(0)};
                if (!i_stat.full[Q_FIRST]) begin
                    o_qop.push = 1'b1;
                end else begin
                    n_drop = 1'b1;
                end
                if ((r_op == OP_NOTIFY_ALL) && !i_stat.empty[Q_BLOCKED]) begin
                    o_qop.pop = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end

            // Pick the next thread and read its entry
            S_SRD: begin
                if (!i_stat.empty[Q_FIRST]) begin
                    o_qop.pop   = 1'b1;
                    o_qop.pop_q = Q_FIRST;
                    n_src2      = 1'b0;
                    n_state     = S_SWB;
                end else if (!i_stat.empty[Q_SECOND]) begin
                    o_qop.pop   = 1'b1;
                    o_qop.pop_q = Q_SECOND;
                    n_src2      = 1'b1;
                    n_state     = S_SWB;
                end else begin
                    n_run   = '0;
                    n_used  = '0;
                    n_quant = '0;
                    n_lvl2  = 1'b0;
                    n_idle  = 1'b1;
                    n_state = S_DONE;
                end
            end

            // Load the chosen thread
            S_SWB: begin
                n_run  = i_rdata[DW-1 -: ID_WIDTH];
                n_idle = 1'b0;
                n_lvl2 = r_src2;
                if (r_src2) begin
                    n_used  = i_rdata[USED_W-1:0];
                    n_quant = i_cfg.second_quantum;
                end else begin
                    n_used  = '0;
                    n_quant = i_cfg.first_quantum;
                end
                n_state = S_DONE;
            end

            // Hand the result to the output register
            S_DONE: begin
                o_done = 1'b1;
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and running-thread state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_run   <= '0;
            r_used  <= '0;
            r_quant <= '0;
            r_idle  <= 1'b1;
            r_lvl2  <= 1'b0;
            r_src2  <= 1'b0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_run   <= n_run;
            r_used  <= n_used;
            r_quant <= n_quant;
            r_idle  <= n_idle;
            r_lvl2  <= n_lvl2;
            r_src2  <= n_src2;
            r_drop  <= n_drop;
        end
    end

    // Latched event payload
    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_tid <= n_tid;
    end

    assign o_running_id = r_idle ? '0 : r_run;
    assign o_is_idle    = r_idle;
    assign o_dropped    = r_drop;

endmodule

`default_nettype wire

>>> rtl/core/two_level_feedback_scheduler_top.sv
// Two-level feedback scheduler: top level with config and output registers.
// Each item runs through the sequencer states: execute decodes it and pushes where needed;
// a notify moves blocked entries to the first queue, one per wake step; a reschedule reads
// the next head from the registered RAM, if a queue holds one, and loads it as running.
// A new item is accepted only after the previous result is loaded into the output register.
// Synchronous active-low reset: queues empty, idle runs, config zero; no RAM clearing pass.
`default_nettype none

module two_level_feedback_scheduler_top import tlfs_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [OP_W-1:0]      i_op,
    input  wire logic [ID_WIDTH-1:0]  i_thread_id,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic      [ID_WIDTH-1:0]  o_running_id,
    output logic                      o_is_idle,
    output logic                      o_dropped,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int DW = ID_WIDTH + USED_W;

    t_cfg                r_cfg;
    t_qop                qop;
    t_qstat              qstat;
    logic [PW-1:0]       tail_slot;
    logic [PW-1:0]       head_slot;
    logic [DW-1:0]       wdata;
    logic [DW-1:0]       rdata;
    logic                ctrl_done;
    logic                out_free;
    logic [ID_WIDTH-1:0] ctrl_run_id;
    logic                ctrl_idle;
    logic                ctrl_drop;
    logic                r_out_valid;
    logic [ID_WIDTH-1:0] r_out_id;
    logic                r_out_idle;
    logic                r_out_drop;

    // Configuration registers, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FIRST_QUANTUM:  r_cfg.first_quantum  <= i_cfg_data;
                CFG_SECOND_QUANTUM: r_cfg.second_quantum <= i_cfg_data;
                CFG_TICK_INTERVAL:  r_cfg.tick_interval  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tlfs_qptr #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_qptr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qop       (qop),
        .o_stat      (qstat),
        .o_tail_slot (tail_slot),
        .o_head_slot (head_slot)
    );

    tlfs_qmem #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .DATA_W      (DW)
    ) u_qmem (
        .i_clk   (i_clk),
        .i_we    (qop.push),
        .i_wq    (qop.push_q),
        .i_wslot (tail_slot),
        .i_wdata (wdata),
        .i_re    (qop.pop),
        .i_rq    (qop.pop_q),
        .i_rslot (head_slot),
        .o_rdata (rdata)
    );

    // The sequencer only looks at its accept input while it is ready
    tlfs_ctrl #(
        .ID_WIDTH (ID_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (i_in_valid),
        .i_op         (i_op),
        .i_thread_id  (i_thread_id),
        .i_cfg        (r_cfg),
        .i_stat       (qstat),
        .i_rdata      (rdata),
        .i_out_free   (out_free),
        .o_qop        (qop),
        .o_wdata      (wdata),
        .o_in_ready   (o_in_ready),
        .o_done       (ctrl_done),
        .o_running_id (ctrl_run_id),
        .o_is_idle    (ctrl_idle),
        .o_dropped    (ctrl_drop)
    );

    // Result register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl_done && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl_done && out_free) begin
            r_out_id   <= ctrl_run_id;
            r_out_idle <= ctrl_idle;
            r_out_drop <= ctrl_drop;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_running_id = r_out_id;
    assign o_is_idle    = r_out_idle;
    assign o_dropped    = r_out_drop;

    // Checks
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("sequencer took an item without leaving idle");

    a_idle_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_idle) |-> (o_running_id == '0))
        else $error("idle result with nonzero thread id");

    a_qstat_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (qstat.empty & qstat.full) == '0)
        else $error("queue both empty and full");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(ctrl_done))
        else $error("result loaded without a finished event");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Testbench of the two-level feedback scheduler: event table, random phases, result scoreboard.
`default_nettype none

module testbench;
    import tlfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ID_W        = 8;
    localparam int QDEPTH      = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 235;
    localparam int NUM_PHASES  = 8;
    localparam int NUM_ROWS    = 24;

    // Event codes the block ignores
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [USED_W-1:0] USED_MAX = '1;

    typedef struct packed {
        logic [ID_W-1:0] running_id;
        logic            is_idle;
        logic            dropped;
    } t_sched_result;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [USED_W-1:0] used;
    } t_demoted;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] tid;
        logic            typed;
        t_sched_result   want;
    } t_directed_row;

    typedef enum {MIX_BALANCED, MIX_ADD_HEAVY, MIX_BLOCK_HEAVY, MIX_TICK_HEAVY} t_mix;

    // DUT signals
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic [OP_W-1:0]      i_op        = OP_ADD;
    logic [ID_W-1:0]      i_thread_id = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [ID_W-1:0]      o_running_id;
    logic                 o_is_idle;
    logic                 o_dropped;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_FIRST_QUANTUM;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    // Predictor state
    t_cfg              sched_cfg = '0;
    logic [ID_W-1:0]   lvl1_ids[$];
    t_demoted          lvl2_q[$];
    logic [ID_W-1:0]   parked_ids[$];
    logic [ID_W-1:0]   cur_id      = '0;
    logic [USED_W-1:0] cur_used    = '0;
    logic [CFG_W-1:0]  cur_quantum = '0;
    logic              cur_idle    = 1'b1;
    logic              cur_lvl2    = 1'b0;

    t_sched_result sched_expected[$];
    int            error_count   = 0;
    int            cycle_count   = 0;
    int            in_idle_pct   = 0;
    int            out_stall_pct = 0;

    // Directed items; the first rows have their results written out
    t_directed_row directed_rows [NUM_ROWS] = '{
        '{OP_TICK,       8'h00, 1'b1, '{8'h00, 1'b1, 1'b0}},
        '{OP_FINISH,     8'h00, 1'b1, '{8'h00, 1'b1, 1'b0}},
        '{OP_BLOCK,      8'h00, 1'b1, '{8'h00, 1'b1, 1'b0}},
        '{OP_NOTIFY,     8'h00, 1'b1, '{8'h00, 1'b1, 1'b0}},
        '{OP_NOTIFY_ALL, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b0}},
        '{OP_RSVD6,      8'h33, 1'b1, '{8'h00, 1'b1, 1'b0}},
        '{OP_RSVD7,      8'hCC, 1'b1, '{8'h00, 1'b1, 1'b0}},
        '{OP_ADD,        8'hFF, 1'b1, '{8'h00, 1'b1, 1'b0}},
        '{OP_ADD,        8'h00, 1'b1, '{8'h00, 1'b1, 1'b0}},
        '{OP_ADD,        8'h5A, 1'b1, '{8'h00, 1'b1, 1'b0}},
        '{OP_TICK,       8'h00, 1'b1, '{8'hFF, 1'b0, 1'b0}},
        '{OP_TICK,       8'h00, 1'b0, '0},
        '{OP_BLOCK,      8'h00, 1'b0, '0},
        '{OP_FINISH,     8'h00, 1'b0, '0},
        '{OP_TICK,       8'h00, 1'b0, '0},
        '{OP_ADD,        8'h81, 1'b0, '0},
        '{OP_NOTIFY,     8'h00, 1'b0, '0},
        '{OP_BLOCK,      8'h00, 1'b0, '0},
        '{OP_BLOCK,      8'h00, 1'b0, '0},
        '{OP_NOTIFY_ALL, 8'h00, 1'b0, '0},
        '{OP_FINISH,     8'h00, 1'b0, '0},
        '{OP_FINISH,     8'h00, 1'b0, '0},
        '{OP_FINISH,     8'h00, 1'b0, '0},
        '{OP_TICK,       8'h00, 1'b0, '0}
    };

    two_level_feedback_scheduler_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_thread_id  (i_thread_id),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_running_id (o_running_id),
        .o_is_idle    (o_is_idle),
        .o_dropped    (o_dropped),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Pick the next thread: first level, then second level, else idle
    function automatic void reschedule();
        t_demoted d;
        if (lvl1_ids.size() != 0) begin
            cur_id      = lvl1_ids[0];
            lvl1_ids.delete(0);
            cur_used    = '0;
            cur_quantum = sched_cfg.first_quantum;
            cur_lvl2    = 1'b0;
            cur_idle    = 1'b0;
        end else if (lvl2_q.size() != 0) begin
            d           = lvl2_q[0];
            lvl2_q.delete(0);
            cur_id      = d.id;
            cur_used    = d.used;
            cur_quantum = sched_cfg.second_quantum;
            cur_lvl2    = 1'b1;
            cur_idle    = 1'b0;
        end else begin
            cur_id      = '0;
            cur_used    = '0;
            cur_quantum = '0;
            cur_lvl2    = 1'b0;
            cur_idle    = 1'b1;
        end
    endfunction

    // Returns 1 when the first-level queue is full and the id is lost
    function automatic logic push_ready(logic [ID_W-1:0] id);
        if (lvl1_ids.size() >= QDEPTH) return 1'b1;
        lvl1_ids.insert(lvl1_ids.size(), id);
        return 1'b0;
    endfunction

    function automatic logic push_demoted(logic [ID_W-1:0] id, logic [USED_W-1:0] used);
        t_demoted d;
        if (lvl2_q.size() >= QDEPTH) return 1'b1;
        d.id   = id;
        d.used = used;
        lvl2_q.insert(lvl2_q.size(), d);
        return 1'b0;
    endfunction

    // Apply one item to the predicted state and return the expected result
    function automatic t_sched_result advance_scheduler(logic [OP_W-1:0] op,
                                                        logic [ID_W-1:0] tid);
        t_sched_result   r;
        logic [USED_W:0] sum;
        logic            dropped;
        logic [ID_W-1:0] woken;
        dropped = 1'b0;
        case (op)
            OP_ADD: begin
                dropped = push_ready(tid);
            end
            OP_FINISH: begin
                reschedule();
            end
            OP_BLOCK: begin
                if (!cur_idle) begin
                    if (parked_ids.size() >= QDEPTH) dropped = 1'b1;
                    else parked_ids.insert(parked_ids.size(), cur_id);
                end
                reschedule();
            end
            OP_NOTIFY: begin
                if (parked_ids.size() != 0) begin
                    woken = parked_ids[0];
                    parked_ids.delete(0);
                    dropped = push_ready(woken);
                end
            end
            OP_NOTIFY_ALL: begin
                while (parked_ids.size() != 0) begin
                    woken = parked_ids[0];
                    parked_ids.delete(0);
                    if (push_ready(woken)) dropped = 1'b1;
                end
            end
            OP_TICK: begin
                if (cur_idle) begin
                    reschedule();
                end else begin
                    sum      = {1'b0, cur_used} + {2'b00, sched_cfg.tick_interval};
                    cur_used = (sum > {1'b0, USED_MAX}) ? USED_MAX : sum[USED_W-1:0];
                    if (cur_used >= {1'b0, cur_quantum}) begin
                        // quantum used up: demote with fresh usage
                        dropped = push_demoted(cur_id, '0);
                        reschedule();
                    end else if (cur_lvl2 && lvl1_ids.size() != 0) begin
                        // second-level thread yields to first-level work
                        dropped = push_demoted(cur_id, cur_used);
                        reschedule();
                    end
                end
            end
            default: ;
        endcase
        r.running_id = cur_idle ? '0 : cur_id;
        r.is_idle    = cur_idle;
        r.dropped    = dropped;
        return r;
    endfunction

    function automatic logic [OP_W-1:0] pick_op(t_mix mix);
        int r;
        int w_add, w_fin, w_blk, w_ntf, w_all, w_tick;
        r = $urandom_range(99);
        case (mix)
            MIX_ADD_HEAVY: begin
                w_add = 60; w_fin = 5; w_blk = 10; w_ntf = 5; w_all = 3; w_tick = 15;
            end
            MIX_BLOCK_HEAVY: begin
                w_add = 30; w_fin = 5; w_blk = 35; w_ntf = 10; w_all = 5; w_tick = 13;
            end
            MIX_TICK_HEAVY: begin
                w_add = 15; w_fin = 5; w_blk = 5; w_ntf = 10; w_all = 5; w_tick = 58;
            end
            default: begin
                w_add = 25; w_fin = 12; w_blk = 15; w_ntf = 12; w_all = 6; w_tick = 26;
            end
        endcase
        if (r < w_add) return OP_ADD;
        r -= w_add;
        if (r < w_fin) return OP_FINISH;
        r -= w_fin;
        if (r < w_blk) return OP_BLOCK;
        r -= w_blk;
        if (r < w_ntf) return OP_NOTIFY;
        r -= w_ntf;
        if (r < w_all) return OP_NOTIFY_ALL;
        r -= w_all;
        if (r < w_tick) return OP_TICK;
        return ($urandom_range(1) != 0) ? OP_RSVD7 : OP_RSVD6;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Offer one item, with random idle cycles ahead of it
    task automatic send_event(logic [OP_W-1:0] op, logic [ID_W-1:0] tid,
                              logic typed, t_sched_result typed_want);
        t_sched_result pred;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        pred = advance_scheduler(op, tid);
        sched_expected.insert(sched_expected.size(), typed ? typed_want : pred);
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_thread_id <= tid;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Wait until every result is back and the block has settled
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sched_expected.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write all registers back to back, optionally the unused index too
    task automatic set_config(logic [CFG_W-1:0] fq, logic [CFG_W-1:0] sq,
                              logic [CFG_W-1:0] ti, bit with_spare);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CFG_W-1:0]     val [4];
        int                   n;
        idx = '{CFG_FIRST_QUANTUM, CFG_SECOND_QUANTUM, CFG_TICK_INTERVAL, CFG_SPARE};
        val = '{fq, sq, ti, CFG_W'($urandom)};
        n   = with_spare ? 4 : 3;
        for (int k = 0; k < n; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx[k])
                CFG_FIRST_QUANTUM:  sched_cfg.first_quantum  = val[k];
                CFG_SECOND_QUANTUM: sched_cfg.second_quantum = val[k];
                CFG_TICK_INTERVAL:  sched_cfg.tick_interval  = val[k];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Result side: random stalls, compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_sched_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (sched_expected.size() == 0) begin
                report_mismatch("result with nothing expected", o_running_id, 0);
            end else begin
                want = sched_expected[0];
                sched_expected.delete(0);
                if (o_running_id !== want.running_id)
                    report_mismatch("running_id", o_running_id, want.running_id);
                if (o_is_idle !== want.is_idle)
                    report_mismatch("is_idle", o_is_idle, want.is_idle);
                if (o_dropped !== want.dropped)
                    report_mismatch("dropped", o_dropped, want.dropped);
            end
        end
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [CFG_W-1:0] fq, sq, ti;
        t_mix             mix;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items with registers at their reset value
        foreach (directed_rows[k])
            send_event(directed_rows[k].op, directed_rows[k].tid,
                       directed_rows[k].typed, directed_rows[k].want);

        // Random phases, each with its own settings and idling
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            case (p)
                0: begin fq = 16'd0;     sq = 16'd0;     ti = 16'd0;     end
                1: begin fq = 16'hFFFF;  sq = 16'hFFFF;  ti = 16'hFFFF;  end
                2: begin fq = 16'd4;     sq = 16'd12;    ti = 16'd1;     end
                3: begin fq = 16'd3;     sq = 16'd7;     ti = 16'd2;     end
                4: begin
                    fq = CFG_W'($urandom_range(20));
                    sq = CFG_W'($urandom_range(40));
                    ti = CFG_W'($urandom_range(5));
                end
                5: begin fq = 16'hFFFF;  sq = 16'd0;     ti = 16'hFFFF;  end
                6: begin
                    fq = CFG_W'($urandom);
                    sq = CFG_W'($urandom);
                    ti = CFG_W'($urandom);
                end
                default: begin fq = 16'd1; sq = 16'hFFFF; ti = 16'd0; end
            endcase
            set_config(fq, sq, ti, p == 3);
            case (p % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 87; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 87; end
                default: begin in_idle_pct = 35; out_stall_pct = 35; end
            endcase
            mix = MIX_BALANCED;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) mix = t_mix'($urandom_range(3));
                send_event(pick_op(mix), ID_W'($urandom), 1'b0, '0);
            end
        end

        out_stall_pct = 0;
        wait_drained();
        repeat (30) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
